// ----- sv/multi_lane_debounced_event_timestamper_top_defines.svh -----
// Assertion macros shared by the timestamper checker.
// No dependencies; the clock and reset names aclk and aresetn must be in scope.
`ifndef MULTI_LANE_DEBOUNCED_EVENT_TIMESTAMPER_TOP_DEFINES_SVH
`define MULTI_LANE_DEBOUNCED_EVENT_TIMESTAMPER_TOP_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define MLDETS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define MLDETS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- sv/mldets_pkg.sv -----
// Types and constants for the multi-lane debounced event timestamper.
// No dependencies.
package mldets_pkg;

    localparam int LEVEL_W     = 8;
    localparam int RUN_W       = 8;
    localparam int GAP_W       = 16;
    localparam int TICK_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    localparam logic             TRIGGER_LEVEL_RST  = 1'b0;
    localparam logic [GAP_W-1:0] MIN_GAP_RST        = 16'd50;
    localparam logic [RUN_W-1:0] DEBOUNCE_COUNT_RST = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TRIGGER_LEVEL  = 2'd0,
        REG_PRESS_GAP      = 2'd1,
        REG_DEBOUNCE_COUNT = 2'd2
    } cfg_reg_t;

endpackage

// ----- sv/multi_lane_debounced_event_timestamper_top.sv -----
// Multi-lane debounced event timestamper: one word per sampling tick, one result word per tick.
// Depends on mldets_pkg.
//
// Every accepted word is one tick of LANES sensor levels (lanes past eight read low). The
// block debounces each lane with saturating run counters, holds off repeat presses for a
// programmable number of ticks, and returns a press mask, a release mask and the 32-bit tick
// count. Rate is one word per clock while the receiver takes results: all lanes are evaluated
// in parallel between the state registers and the single output register, so a result appears
// in the cycle after its word is accepted, and a new word is taken in the same cycle the
// waiting result is taken. Configuration writes take effect on the next clock and are meant
// for idle periods only.
module multi_lane_debounced_event_timestamper_top #(
    parameter int LANES = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mldets_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mldets_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mldets_pkg::LEVEL_W-1:0]      s_raw_levels,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mldets_pkg::LEVEL_W-1:0]      m_press_mask,
    output logic [mldets_pkg::LEVEL_W-1:0]      m_release_mask,
    output logic [mldets_pkg::TICK_W-1:0]       m_timestamp
);
    import mldets_pkg::*;

    localparam int VEC_W = (LANES > LEVEL_W) ? LANES : LEVEL_W;

    // configuration
    logic             trig_level_reg;
    logic [GAP_W-1:0] min_gap_reg;
    logic [RUN_W-1:0] debounce_reg;

    // lane state
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [RUN_W-1:0]  trig_run_reg [LANES];
    logic [RUN_W-1:0]  trig_run_next [LANES];
    logic [RUN_W-1:0]  rel_run_reg [LANES];
    logic [RUN_W-1:0]  rel_run_next [LANES];
    logic [LANES-1:0]  active_reg, active_next;
    logic [TICK_W-1:0] last_press_reg [LANES];
    logic [TICK_W-1:0] last_press_next [LANES];

    // output stage
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] press_mask_reg;
    logic [LEVEL_W-1:0] release_mask_reg;
    logic [TICK_W-1:0]  timestamp_reg;

    logic [VEC_W-1:0] lane_level;
    logic [VEC_W-1:0] press_vec;
    logic [VEC_W-1:0] release_vec;
    logic             in_acc;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        logic              hit;
        logic              pressed;
        logic              active_mid;
        logic [TICK_W-1:0] elapsed;
        tick_next  = tick_reg + 1'b1;
        lane_level = '0;
        lane_level[LEVEL_W-1:0] = s_raw_levels;
        press_vec   = '0;
        release_vec = '0;
        for (int l = 0; l < LANES; l++) begin
            hit = (lane_level[l] == trig_level_reg);
            if (hit) begin
                trig_run_next[l] = (trig_run_reg[l] == RUN_MAX) ? RUN_MAX
                                                                : trig_run_reg[l] + 1'b1;
                rel_run_next[l]  = '0;
            end else begin
                trig_run_next[l] = '0;
                rel_run_next[l]  = (rel_run_reg[l] == RUN_MAX) ? RUN_MAX
                                                               : rel_run_reg[l] + 1'b1;
            end
            // wrap-safe elapsed ticks since the last accepted press
            elapsed = tick_next - last_press_reg[l];
            pressed = !active_reg[l] && (trig_run_next[l] == debounce_reg)
                      && (elapsed >= {{(TICK_W-GAP_W){1'b0}}, min_gap_reg});
            // press test first, release test sees the updated active flag
            active_mid         = active_reg[l] || pressed;
            press_vec[l]       = pressed;
            release_vec[l]     = active_mid && (rel_run_next[l] == debounce_reg);
            active_next[l]     = active_mid && !release_vec[l];
            last_press_next[l] = pressed ? tick_next : last_press_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_level_reg <= TRIGGER_LEVEL_RST;
            min_gap_reg    <= MIN_GAP_RST;
            debounce_reg   <= DEBOUNCE_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_TRIGGER_LEVEL:  trig_level_reg <= cfg_wdata[0];
                REG_PRESS_GAP:      min_gap_reg    <= cfg_wdata[GAP_W-1:0];
                REG_DEBOUNCE_COUNT: debounce_reg   <= cfg_wdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int l = 0; l < LANES; l++) begin
                trig_run_reg[l]   <= '0;
                rel_run_reg[l]    <= '0;
                last_press_reg[l] <= '0;
            end
        end else begin
            m_valid_reg <= in_acc || (m_valid_reg && !m_ready);
            if (in_acc) begin
                tick_reg   <= tick_next;
                active_reg <= active_next;
                for (int l = 0; l < LANES; l++) begin
                    trig_run_reg[l]   <= trig_run_next[l];
                    rel_run_reg[l]    <= rel_run_next[l];
                    last_press_reg[l] <= last_press_next[l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            press_mask_reg   <= press_vec[LEVEL_W-1:0];
            release_mask_reg <= release_vec[LEVEL_W-1:0];
            timestamp_reg    <= tick_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_press_mask   = press_mask_reg;
    assign m_release_mask = release_mask_reg;
    assign m_timestamp    = timestamp_reg;

endmodule

// ----- sv/mldets_checker.sv -----
// Port-level checker for the timestamper, bound to the top level.
// Depends on mldets_pkg and multi_lane_debounced_event_timestamper_top_defines.svh.
`include "multi_lane_debounced_event_timestamper_top_defines.svh"

module mldets_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mldets_pkg::LEVEL_W-1:0]      m_press_mask,
    input logic [mldets_pkg::LEVEL_W-1:0]      m_release_mask,
    input logic [mldets_pkg::TICK_W-1:0]       m_timestamp
);
    import mldets_pkg::*;

    logic              seen_reg;
    logic [TICK_W-1:0] last_ts_reg;
    logic              out_acc;

    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b0;
            last_ts_reg <= '0;
        end else if (out_acc) begin
            seen_reg    <= 1'b1;
            last_ts_reg <= m_timestamp;
        end
    end

    // a stalled result word holds
    `MLDETS_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_timestamp) && $stable(m_press_mask) && $stable(m_release_mask), "result word changed while stalled")

    // every accepted word yields a result on the next cycle
    `MLDETS_ASSERT(a_result, s_valid && s_ready |=> m_valid, "accepted word produced no result")

    // an empty output stage never blocks the input
    `MLDETS_ASSERT(a_ready, !m_valid |-> s_ready, "input stalled with empty output")

    // a lane cannot press and release in the same tick
    `MLDETS_ASSERT(a_disjoint, m_valid |-> (m_press_mask & m_release_mask) == '0, "press and release on one lane")

    // consecutive results carry consecutive ticks
    `MLDETS_ASSERT(a_tick_step, out_acc && seen_reg |-> m_timestamp == last_ts_reg + 1'b1, "timestamp skipped or repeated")

endmodule

bind multi_lane_debounced_event_timestamper_top mldets_checker u_mldets_checker (.*);

// ----- dv/multi_lane_debounced_event_timestamper_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for multi_lane_debounced_event_timestamper_top: a directed table, then
// random phases of debounced lane patterns under several settings. Depends on mldets_pkg.
module multi_lane_debounced_event_timestamper_top_tb;

    import mldets_pkg::*;

    localparam int LANE_COUNT   = LEVEL_W;
    localparam int RUN_LIMIT_NS = 10_000_000;
    // index 3 decodes to no register; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] press_mask;
        logic [LEVEL_W-1:0] release_mask;
        logic [TICK_W-1:0]  timestamp;
    } tick_result_t;

    typedef struct {
        int unsigned  seq;
        tick_result_t res;
    } pinned_result_t;

    typedef enum {ROW_WORD, ROW_SETTING} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [LEVEL_W-1:0]     levels;
        logic                   pinned;
        tick_result_t           res;
        logic [CFG_INDEX_W-1:0] sel;
        logic [CFG_DATA_W-1:0]  value;
    } stim_row_t;

    typedef enum {RDY_OPEN, RDY_LIGHT, RDY_HEAVY, RDY_PULSE} ready_style_t;

    logic                   aclk;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [LEVEL_W-1:0]     s_raw_levels = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [LEVEL_W-1:0]     m_press_mask;
    logic [LEVEL_W-1:0]     m_release_mask;
    logic [TICK_W-1:0]      m_timestamp;

    // lane model
    logic                   sense_level;
    logic [GAP_W-1:0]       min_gap;
    logic [RUN_W-1:0]       debounce_len;
    logic [TICK_W-1:0]      tick_now;
    logic [RUN_W-1:0]       trig_run   [LANE_COUNT];
    logic [RUN_W-1:0]       rel_run    [LANE_COUNT];
    logic                   lane_on    [LANE_COUNT];
    logic [TICK_W-1:0]      last_press [LANE_COUNT];

    tick_result_t   pending_results[$];
    pinned_result_t pinned_results[$];
    stim_row_t      rows[$];

    int unsigned  mismatch_count = 0;
    int unsigned  words_sent     = 0;
    int unsigned  words_taken    = 0;
    int unsigned  results_seen   = 0;
    int unsigned  burst_left     = 0;
    int unsigned  ready_left     = 0;
    ready_style_t ready_style    = RDY_OPEN;

    multi_lane_debounced_event_timestamper_top #(
        .LANES(LANE_COUNT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_levels  (s_raw_levels),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_press_mask  (m_press_mask),
        .m_release_mask(m_release_mask),
        .m_timestamp   (m_timestamp)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // One tick of every lane: runs first, then press test, then release test.
    function automatic tick_result_t advance_tick(input logic [LEVEL_W-1:0] levels);
        tick_result_t r;
        logic         hit;
        r = '0;
        tick_now = tick_now + 1'b1;
        r.timestamp = tick_now;
        for (int l = 0; l < LANE_COUNT; l++) begin
            hit = (levels[l] == sense_level);
            if (hit) begin
                if (trig_run[l] != RUN_MAX) trig_run[l] = trig_run[l] + 1'b1;
                rel_run[l] = '0;
            end else begin
                trig_run[l] = '0;
                if (rel_run[l] != RUN_MAX) rel_run[l] = rel_run[l] + 1'b1;
            end
            // elapsed ticks wrap modulo 2^32
            if (!lane_on[l] && trig_run[l] == debounce_len
                    && TICK_W'(tick_now - last_press[l]) >= TICK_W'(min_gap)) begin
                last_press[l]   = tick_now;
                lane_on[l]      = 1'b1;
                r.press_mask[l] = 1'b1;
            end
            if (lane_on[l] && rel_run[l] == debounce_len) begin
                lane_on[l]        = 1'b0;
                r.release_mask[l] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TICK_W-1:0] want,
                                        input logic [TICK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Model, scoreboard and config shadow, all sampled at the clock edge.
    always @(posedge aclk) begin
        tick_result_t   want;
        pinned_result_t pin;
        if (!aresetn) begin
            sense_level  = TRIGGER_LEVEL_RST;
            min_gap      = MIN_GAP_RST;
            debounce_len = DEBOUNCE_COUNT_RST;
            tick_now     = '0;
            foreach (trig_run[l]) begin
                trig_run[l]   = '0;
                rel_run[l]    = '0;
                lane_on[l]    = 1'b0;
                last_press[l] = '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("press_mask", TICK_W'(want.press_mask), TICK_W'(m_press_mask));
                    check_field("release_mask", TICK_W'(want.release_mask),
                                TICK_W'(m_release_mask));
                    check_field("timestamp", want.timestamp, m_timestamp);
                end
            end
            if (s_valid && s_ready) begin
                want = advance_tick(s_raw_levels);
                if (pinned_results.size() != 0 && pinned_results[0].seq == words_taken) begin
                    pin  = pinned_results.pop_front();
                    want = pin.res;
                end
                pending_results.push_back(want);
                words_taken++;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TRIGGER_LEVEL:  sense_level  = cfg_wdata[0];
                    REG_PRESS_GAP:      min_gap      = cfg_wdata[GAP_W-1:0];
                    REG_DEBOUNCE_COUNT: debounce_len = cfg_wdata[RUN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: picks a new stall style at random whenever the current one runs out.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_left  = $urandom_range(20, 150);
        end
        ready_left--;
        case (ready_style)
            RDY_OPEN:  m_ready <= 1'b1;
            RDY_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
            RDY_HEAVY: m_ready <= ($urandom_range(0, 2) == 0);
            default:   m_ready <= ((ready_left % 4) < 2);
        endcase
    end

    function automatic void add_word(input logic [LEVEL_W-1:0] levels, input logic pinned,
                                     input tick_result_t res);
        stim_row_t r;
        r.kind   = ROW_WORD;
        r.levels = levels;
        r.pinned = pinned;
        r.res    = res;
        r.sel    = '0;
        r.value  = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_setting(input logic [CFG_INDEX_W-1:0] sel,
                                        input logic [CFG_DATA_W-1:0] value);
        stim_row_t r;
        r.kind   = ROW_SETTING;
        r.levels = '0;
        r.pinned = 1'b0;
        r.res    = '0;
        r.sel    = sel;
        r.value  = value;
        rows.push_back(r);
    endfunction

    // Sender works in bursts; gaps land only at a burst boundary, before a burst's first word.
    task automatic send_word(input logic [LEVEL_W-1:0] levels);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 15) == 0) begin
                burst_left = 200;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_raw_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (results_seen != words_sent) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int unsigned hold_span(input logic [RUN_W-1:0] deb);
        int unsigned lo;
        int unsigned hi;
        lo = (deb > 1) ? deb - 1 : 1;
        hi = deb + 3;
        if ($urandom_range(0, 7) == 0) hi = 2 * deb + 8;
        return $urandom_range(lo, hi);
    endfunction

    // Each lane holds a level for about the debounce length, with glitches and noise words.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] trig_data,
                             input logic [CFG_DATA_W-1:0] gap_data,
                             input logic [CFG_DATA_W-1:0] deb_data, input int unsigned count);
        logic [LEVEL_W-1:0] held;
        logic [LEVEL_W-1:0] word;
        logic [RUN_W-1:0]   deb;
        int unsigned        hold_left [LANE_COUNT];
        int unsigned        pick;
        wait_drained();
        write_reg(REG_TRIGGER_LEVEL, trig_data);
        write_reg(REG_PRESS_GAP, gap_data);
        write_reg(REG_DEBOUNCE_COUNT, deb_data);
        deb  = deb_data[RUN_W-1:0];
        held = LEVEL_W'($urandom);
        foreach (hold_left[l]) hold_left[l] = hold_span(deb);
        repeat (count) begin
            for (int l = 0; l < LANE_COUNT; l++) begin
                if (hold_left[l] == 0) begin
                    held[l]      = ~held[l];
                    hold_left[l] = hold_span(deb);
                end
                hold_left[l]--;
            end
            // runs only reach saturation on clean holds
            pick = (deb == RUN_MAX) ? 2 : $urandom_range(0, 19);
            if (pick == 0)
                word = LEVEL_W'($urandom);
            else if (pick == 1)
                word = held ^ (LEVEL_W'(1) << $urandom_range(0, LANE_COUNT - 1));
            else
                word = held;
            send_word(word);
        end
    endtask

    initial begin
        // defaults: level 0 triggers, gap 50, debounce 3; third low sample is gap-blocked
        add_word(8'hFF, 1'b1, '{8'h00, 8'h00, 32'd1});
        add_word(8'h00, 1'b1, '{8'h00, 8'h00, 32'd2});
        add_word(8'h00, 1'b1, '{8'h00, 8'h00, 32'd3});
        add_word(8'h00, 1'b1, '{8'h00, 8'h00, 32'd4});
        add_setting(REG_PRESS_GAP, 16'd0);
        add_word(8'h00, 1'b0, '0);
        repeat (3) add_word(8'hFF, 1'b0, '0);
        repeat (3) add_word(8'h00, 1'b0, '0);
        repeat (3) add_word(8'h0F, 1'b0, '0);
        add_word(8'hA5, 1'b0, '0);
        add_word(8'h5A, 1'b0, '0);
        // zero debounce: cleared runs match right away
        add_setting(REG_DEBOUNCE_COUNT, 16'd0);
        add_word(8'hFF, 1'b0, '0);
        add_word(8'h00, 1'b0, '0);
        add_setting(REG_TRIGGER_LEVEL, 16'd1);
        add_setting(REG_DEBOUNCE_COUNT, 16'd1);
        add_word(8'hFF, 1'b0, '0);
        add_word(8'h00, 1'b0, '0);
        add_word(8'h80, 1'b0, '0);
        add_word(8'h01, 1'b0, '0);
        add_setting(REG_PRESS_GAP, 16'hFFFF);
        add_word(8'hFF, 1'b0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_SETTING) begin
                wait_drained();
                write_reg(rows[i].sel, rows[i].value);
            end else begin
                if (rows[i].pinned) pinned_results.push_back('{words_sent, rows[i].res});
                send_word(rows[i].levels);
            end
        end

        run_phase(16'd1, 16'd0, 16'd1, 180);
        run_phase(16'd0, 16'd12, 16'd3, 220);
        run_phase(16'd1, 16'hFFFF, 16'd4, 100);
        // saturated runs, gap longer than a hold cycle so presses wait at run 255
        run_phase(16'd0, 16'd600, 16'd255, 650);
        run_phase(16'd1, 16'd25, 16'd0, 150);
        wait_drained();
        write_reg(SPARE_INDEX, CFG_DATA_W'($urandom));
        run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 80)),
                  {8'($urandom), 8'($urandom_range(1, 8))}, 150);
        run_phase(16'd0, 16'd2, 16'd2, 180);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
